FILE: sv/dlcr_pkg.sv
// Package with the shared constants and types of the DDA line color rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package dlcr_pkg;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int COLOR_BITS = 8;
    localparam int DIV_W      = COORD_BITS + FRAC_BITS;
    localparam int DEN_W      = COORD_BITS + 1;
    localparam int XSTEP_W    = FRAC_BITS + 2;
    localparam int XACC_W     = COORD_BITS + FRAC_BITS + 1;
    localparam int CACC_W     = COLOR_BITS + FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int LANES      = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic load;
        logic iter;
        logic commit;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_hold;
    } t_status;
endpackage
`default_nettype wire

FILE: sv/dlcr_if.sv
// Request and pixel channel interfaces of the DDA line color rasterizer.
`timescale 1ns / 1ps
`default_nettype none
interface dlcr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic signed [dlcr_pkg::COORD_BITS-1:0] start_x;
    logic signed [dlcr_pkg::COORD_BITS-1:0] start_y;
    logic signed [dlcr_pkg::COORD_BITS-1:0] end_x;
    logic signed [dlcr_pkg::COORD_BITS-1:0] end_y;
    logic [dlcr_pkg::COLOR_BITS-1:0]        start_red;
    logic [dlcr_pkg::COLOR_BITS-1:0]        start_green;
    logic [dlcr_pkg::COLOR_BITS-1:0]        start_blue;
    logic [dlcr_pkg::COLOR_BITS-1:0]        end_red;
    logic [dlcr_pkg::COLOR_BITS-1:0]        end_green;
    logic [dlcr_pkg::COLOR_BITS-1:0]        end_blue;

    modport source (
        output valid, operation, start_x, start_y, end_x, end_y,
        output start_red, start_green, start_blue, end_red, end_green, end_blue,
        input  ready
    );
    modport sink (
        input  valid, operation, start_x, start_y, end_x, end_y,
        input  start_red, start_green, start_blue, end_red, end_green, end_blue,
        output ready
    );
endinterface

interface dlcr_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dlcr_pkg::COORD_BITS-1:0] pixel_x;
    logic signed [dlcr_pkg::COORD_BITS-1:0] pixel_y;
    logic [dlcr_pkg::COLOR_BITS-1:0]        red;
    logic [dlcr_pkg::COLOR_BITS-1:0]        green;
    logic [dlcr_pkg::COLOR_BITS-1:0]        blue;
    logic                                  last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, red, green, blue, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, red, green, blue, last_pixel,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/dlcr_ctrl.sv
// Controller state machine that sequences line setup and pixel requests.
`timescale 1ns / 1ps
`default_nettype none
module dlcr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_operation,
    input  wire dlcr_pkg::t_status i_status,
    output logic                   o_ready,
    output dlcr_pkg::t_cmd         o_cmd
);
    import dlcr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DIV    = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign o_ready  = (r_state == S_IDLE) && !i_status.out_hold;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_operation == OP_LOAD) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end else if (w_accept && i_operation == OP_STEP) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.iter = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule
`default_nettype wire

FILE: sv/dlcr_dp.sv
// Datapath with the setup dividers, the position and color accumulators and the pixel register.
`timescale 1ns / 1ps
`default_nettype none
module dlcr_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire dlcr_pkg::t_cmd                        i_cmd,
    output dlcr_pkg::t_status                          o_status,
    input  wire logic signed [dlcr_pkg::COORD_BITS-1:0] i_start_x,
    input  wire logic signed [dlcr_pkg::COORD_BITS-1:0] i_start_y,
    input  wire logic signed [dlcr_pkg::COORD_BITS-1:0] i_end_x,
    input  wire logic signed [dlcr_pkg::COORD_BITS-1:0] i_end_y,
    input  wire logic [dlcr_pkg::COLOR_BITS-1:0]        i_start_red,
    input  wire logic [dlcr_pkg::COLOR_BITS-1:0]        i_start_green,
    input  wire logic [dlcr_pkg::COLOR_BITS-1:0]        i_start_blue,
    input  wire logic [dlcr_pkg::COLOR_BITS-1:0]        i_end_red,
    input  wire logic [dlcr_pkg::COLOR_BITS-1:0]        i_end_green,
    input  wire logic [dlcr_pkg::COLOR_BITS-1:0]        i_end_blue,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic signed [dlcr_pkg::COORD_BITS-1:0]      o_pixel_x,
    output logic signed [dlcr_pkg::COORD_BITS-1:0]      o_pixel_y,
    output logic [dlcr_pkg::COLOR_BITS-1:0]             o_red,
    output logic [dlcr_pkg::COLOR_BITS-1:0]             o_green,
    output logic [dlcr_pkg::COLOR_BITS-1:0]             o_blue,
    output logic                                       o_last_pixel
);
    import dlcr_pkg::*;

    localparam logic [XACC_W-1:0] HALF = XACC_W'(1) << (FRAC_BITS - 1);

    // Setup arithmetic on the incoming request.
    logic [COORD_BITS:0]     w_dx, w_dy;
    logic [COORD_BITS:0]     w_adx_full, w_ady_full;
    logic [COORD_BITS-1:0]   w_adx, w_ady, w_steps;
    logic [DEN_W-1:0]        w_den_xy, w_den_c;
    logic [COLOR_BITS-1:0]   w_c0 [3];
    logic [COLOR_BITS-1:0]   w_c1 [3];
    logic [COLOR_BITS:0]     w_cd [3];
    logic [COLOR_BITS:0]     w_cd_abs [3];
    logic [COORD_BITS-1:0]   w_mag [LANES];
    logic                    w_neg [LANES];

    // Divider lanes: x, y, red, green, blue.
    logic [DEN_W-1:0]        r_rem [LANES];
    logic [DIV_W-1:0]        r_dq [LANES];
    logic                    r_neg [LANES];
    logic [DEN_W-1:0]        r_den_xy, r_den_c;

    // Line state.
    logic [XACC_W-1:0]       r_x_acc, r_y_acc;
    logic [XSTEP_W-1:0]      r_x_step, r_y_step;
    logic [CACC_W-1:0]       r_c_acc [3];
    logic [CACC_W-1:0]       r_c_step [3];
    logic [DEN_W-1:0]        r_left;
    logic                    r_active;

    logic                    r_o_valid;
    logic [COORD_BITS-1:0]   r_o_x, r_o_y;
    logic [COLOR_BITS-1:0]   r_o_c [3];
    logic                    r_o_last;

    logic [XSTEP_W-1:0]      w_xq, w_yq;
    logic [COORD_BITS-1:0]   w_rx, w_ry;
    logic                    w_emit;

    function automatic logic [COORD_BITS-1:0] round_coord(input logic [XACC_W-1:0] a);
        logic [XACC_W-1:0]     mag;
        logic [XACC_W-1:0]     sum;
        logic [COORD_BITS:0]   r;
        mag = a[XACC_W-1] ? -a : a;
        sum = mag + HALF;
        r   = sum[XACC_W-1:FRAC_BITS];
        return a[XACC_W-1] ? COORD_BITS'(-r) : COORD_BITS'(r);
    endfunction

    assign w_dx       = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
    assign w_dy       = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};
    assign w_adx_full = w_dx[COORD_BITS] ? -w_dx : w_dx;
    assign w_ady_full = w_dy[COORD_BITS] ? -w_dy : w_dy;
    assign w_adx      = w_adx_full[COORD_BITS-1:0];
    assign w_ady      = w_ady_full[COORD_BITS-1:0];
    assign w_steps    = (w_adx > w_ady) ? w_adx : w_ady;
    assign w_den_xy   = (w_steps == '0) ? DEN_W'(1) : DEN_W'(w_steps);
    assign w_den_c    = DEN_W'(w_steps) + 1'b1;

    assign w_c0[0] = i_start_red;
    assign w_c0[1] = i_start_green;
    assign w_c0[2] = i_start_blue;
    assign w_c1[0] = i_end_red;
    assign w_c1[1] = i_end_green;
    assign w_c1[2] = i_end_blue;

    always_comb begin
        w_mag[0] = w_adx;
        w_neg[0] = w_dx[COORD_BITS];
        w_mag[1] = w_ady;
        w_neg[1] = w_dy[COORD_BITS];
        for (int k = 0; k < 3; k++) begin
            w_cd[k]      = {1'b0, w_c1[k]} - {1'b0, w_c0[k]};
            w_cd_abs[k]  = w_cd[k][COLOR_BITS] ? -w_cd[k] : w_cd[k];
            w_mag[2 + k] = COORD_BITS'(w_cd_abs[k][COLOR_BITS-1:0]);
            w_neg[2 + k] = w_cd[k][COLOR_BITS];
        end
    end

    // One restoring quotient bit per lane and cycle.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            if (i_cmd.load) begin
                r_rem[k] <= '0;
                r_dq[k]  <= {w_mag[k], {FRAC_BITS{1'b0}}};
                r_neg[k] <= w_neg[k];
            end else if (i_cmd.iter) begin
                if ({r_rem[k], r_dq[k][DIV_W-1]} >=
                        {1'b0, (k < 2) ? r_den_xy : r_den_c}) begin
                    r_rem[k] <= DEN_W'({r_rem[k], r_dq[k][DIV_W-1]} -
                                {1'b0, (k < 2) ? r_den_xy : r_den_c});
                    r_dq[k]  <= {r_dq[k][DIV_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= DEN_W'({r_rem[k], r_dq[k][DIV_W-1]});
                    r_dq[k]  <= {r_dq[k][DIV_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.load) begin
            r_den_xy <= w_den_xy;
            r_den_c  <= w_den_c;
        end
    end

    assign w_xq   = XSTEP_W'(r_dq[0][FRAC_BITS:0]);
    assign w_yq   = XSTEP_W'(r_dq[1][FRAC_BITS:0]);
    assign w_emit = i_cmd.step && r_active;
    assign w_rx   = round_coord(r_x_acc);
    assign w_ry   = round_coord(r_y_acc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_acc <= {i_start_x[COORD_BITS-1], i_start_x, {FRAC_BITS{1'b0}}};
            r_y_acc <= {i_start_y[COORD_BITS-1], i_start_y, {FRAC_BITS{1'b0}}};
            for (int k = 0; k < 3; k++) begin
                r_c_acc[k] <= {1'b0, w_c0[k], {FRAC_BITS{1'b0}}};
            end
        end else if (w_emit && r_left != DEN_W'(1)) begin
            r_x_acc <= r_x_acc + {{(XACC_W - XSTEP_W){r_x_step[XSTEP_W-1]}}, r_x_step};
            r_y_acc <= r_y_acc + {{(XACC_W - XSTEP_W){r_y_step[XSTEP_W-1]}}, r_y_step};
            for (int k = 0; k < 3; k++) begin
                r_c_acc[k] <= r_c_acc[k] + r_c_step[k];
            end
        end
        if (i_cmd.commit) begin
            r_x_step <= r_neg[0] ? -w_xq : w_xq;
            r_y_step <= r_neg[1] ? -w_yq : w_yq;
            for (int k = 0; k < 3; k++) begin
                r_c_step[k] <= r_neg[2 + k] ?
                    -CACC_W'(r_dq[2 + k][COLOR_BITS+FRAC_BITS-1:0]) :
                     CACC_W'(r_dq[2 + k][COLOR_BITS+FRAC_BITS-1:0]);
            end
        end
        if (w_emit) begin
            r_o_x    <= w_rx;
            r_o_y    <= w_ry;
            r_o_last <= (r_left == DEN_W'(1));
            for (int k = 0; k < 3; k++) begin
                // The accumulator stays between the two end colors.
                r_o_c[k] <= r_c_acc[k][CACC_W-1] ? '0 :
                            r_c_acc[k][COLOR_BITS+FRAC_BITS-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_active <= 1'b0;
                r_left   <= w_den_c;
            end else if (i_cmd.commit) begin
                r_active <= 1'b1;
            end else if (w_emit) begin
                r_left <= r_left - 1'b1;
                if (r_left == DEN_W'(1)) begin
                    r_active <= 1'b0;
                end
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_hold = r_o_valid && !i_out_ready;
    assign o_out_valid       = r_o_valid;
    assign o_pixel_x         = r_o_x;
    assign o_pixel_y         = r_o_y;
    assign o_red             = r_o_c[0];
    assign o_green           = r_o_c[1];
    assign o_blue            = r_o_c[2];
    assign o_last_pixel      = r_o_last;
endmodule
`default_nettype wire

FILE: sv/dda_line_color_rasterizer_top.sv
// Top level of the DDA line color rasterizer.
`timescale 1ns / 1ps
`default_nettype none
// A load request is accepted, then the five setup divisions (x and y increments and
// three color increments) run in parallel at one quotient bit per cycle, and the
// S_COMMIT state then commits the increments. No request is taken during that time.
// A step request yields one pixel from the position and color accumulators;
// steps are accepted every cycle while the pixel
// register is free or being emptied in the same cycle. A step with no line loaded gives
// no pixel, and a load always replaces the current line.
module dda_line_color_rasterizer_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dlcr_in_if.sink    i_req,
    dlcr_out_if.source o_pix
);
    import dlcr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_ready;

    assign i_req.ready = w_ready;

    dlcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .i_operation (i_req.operation),
        .i_status    (w_status),
        .o_ready     (w_ready),
        .o_cmd       (w_cmd)
    );

    dlcr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_start_x     (i_req.start_x),
        .i_start_y     (i_req.start_y),
        .i_end_x       (i_req.end_x),
        .i_end_y       (i_req.end_y),
        .i_start_red   (i_req.start_red),
        .i_start_green (i_req.start_green),
        .i_start_blue  (i_req.start_blue),
        .i_end_red     (i_req.end_red),
        .i_end_green   (i_req.end_green),
        .i_end_blue    (i_req.end_blue),
        .i_out_ready   (o_pix.ready),
        .o_out_valid   (o_pix.valid),
        .o_pixel_x     (o_pix.pixel_x),
        .o_pixel_y     (o_pix.pixel_y),
        .o_red         (o_pix.red),
        .o_green       (o_pix.green),
        .o_blue        (o_pix.blue),
        .o_last_pixel  (o_pix.last_pixel)
    );

`ifndef SYNTH
    // A new pixel appears only after an accepted step request.
    a_pixel_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pix.valid) |-> $past(i_req.valid && i_req.ready && i_req.operation))
        else $error("pixel appeared without a step request");

    // No request is taken while the dividers run.
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.iter |-> !i_req.ready)
        else $error("request accepted during line setup");

    // The increments are committed right after the last divider iteration.
    a_commit_after_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> $past(w_cmd.iter))
        else $error("commit without preceding division");
`endif
endmodule
`default_nettype wire
